// File: hdl/ufbs_pkg.sv
// Shared types and constants for the UART fractional baud divider search.
// Used by the serial divider, the search sequencer and the top level.
package ufbs_pkg;

    // Serial divider geometry: dividend and quotient width, divisor and remainder width
    localparam int DIV_W  = 30;
    localparam int DIVR_W = 22;
    localparam int DIV_STEPS = DIV_W;

    localparam int FRAC_MAX_DEF = 15;

    localparam int BAUD_W  = 22;
    localparam int PCT_W   = 7;
    localparam int CLK_W   = 32;
    localparam int BASE_W  = CLK_W - 6;
    localparam int ERR_W   = 17;
    localparam int DVSR_W  = 16;
    localparam int FRAC_W  = 4;
    localparam int LIMIT_W = 23;
    localparam int CAND_W  = DIV_W + 1;

    localparam logic [ERR_W-1:0] NO_ERROR_YET = ERR_W'(100000);
    localparam int DIV_MIN   = 3;
    localparam int DIV_MAX   = 65535;
    localparam int LIMIT_DEN = 100;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CORE_CLOCK = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ERR_PCT    = CFG_IDX_W'(1);

    localparam logic [CLK_W-1:0] CORE_CLOCK_RST = CLK_W'(100000000);
    localparam logic [PCT_W-1:0] ERR_PCT_RST    = PCT_W'(3);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LIMIT,
        S_LAUNCH,
        S_SCALE,
        S_DIVQ,
        S_CHECK,
        S_RATE,
        S_ADVANCE,
        S_FINISH
    } srch_state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [DIVR_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic              valid;
        logic              status;
        logic [DVSR_W-1:0] divisor;
        logic [FRAC_W-1:0] mul_value;
        logic [FRAC_W-1:0] add_value;
        logic [ERR_W-1:0]  rate_error;
    } srch_res_t;

endpackage

// File: hdl/uart_fractional_baud_search.sv
// Top level of the UART fractional baud divider search: config registers,
// stream handshakes and result register. Depends on ufbs_pkg, ufbs_div, ufbs_search.
//
//  Channel  Direction  Ports                         Contents
//  s_       in         s_tvalid s_tready s_tdata     target_baud
//  m_       out        m_tvalid m_tready m_tdata     divisor, mul, add, error
//                      m_tuser                       status
//  cfg_     in         cfg_valid cfg_ready           cfg_index, cfg_data
//
// One item runs one limit divide, then two divides per multiplier/add pair and a third
// for a pair with an in-range divisor (up to (FRAC_MAX)*(FRAC_MAX+1) pairs); every divide
// goes through the shared bit-serial divider, which sets how long an item runs.
// An exact match ends the search early; a zero baud finishes after the limit divide.
// Reset is synchronous on aresetn; it restores the config registers to defaults.
// A finished result waits in the output register; the next item is taken
// meanwhile, and its search stalls at the end until that register frees up.
module uart_fractional_baud_search #(
    parameter int FRAC_MAX = ufbs_pkg::FRAC_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [21:0] target_baud, [23:22] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [15:0] divisor, [19:16] mul_value,
                                    // [23:20] add_value, [40:24] rate_error, [47:41] zero
    output logic        m_tuser,    // [0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [ufbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    import ufbs_pkg::*;

    logic [CLK_W-1:0]  core_clock_reg, core_clock_next;
    logic [PCT_W-1:0]  err_pct_reg, err_pct_next;
    logic              out_valid_reg, out_valid_next;
    srch_res_t         out_reg, out_next;

    logic              srch_idle;
    logic              res_ready;
    logic              in_xfer;
    srch_res_t         res;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    assign cfg_ready = 1'b1;
    assign s_tready  = srch_idle;
    assign in_xfer   = s_tvalid && s_tready;
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        core_clock_next = core_clock_reg;
        err_pct_next    = err_pct_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_IDX_CORE_CLOCK: core_clock_next = cfg_data;
                CFG_IDX_ERR_PCT:    err_pct_next    = cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // Load a finished result on transfer; drop it once the sink takes it
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res.valid && res_ready) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            core_clock_reg <= CORE_CLOCK_RST;
            err_pct_reg    <= ERR_PCT_RST;
            out_valid_reg  <= 1'b0;
        end else begin
            core_clock_reg <= core_clock_next;
            err_pct_reg    <= err_pct_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    ufbs_search #(
        .FRAC_MAX(FRAC_MAX)
    ) u_search (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (in_xfer),
        .target_baud  (s_tdata[BAUD_W-1:0]),
        .core_clock_hz(core_clock_reg),
        .err_percent  (err_pct_reg),
        .res_ready    (res_ready),
        .idle         (srch_idle),
        .res          (res),
        .div_req      (div_req),
        .div_rsp      (div_rsp)
    );

    ufbs_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'b0, out_reg.rate_error, out_reg.add_value,
                       out_reg.mul_value, out_reg.divisor};

endmodule

// File: hdl/ufbs_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ufbs_pkg for widths and the request/response structs.
module ufbs_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  ufbs_pkg::div_req_t  req,
    output ufbs_pkg::div_rsp_t  rsp
);
    import ufbs_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_W-1:0]  q_reg, q_next;
    logic [DIVR_W-1:0] rem_reg, rem_next;
    logic [DIVR_W-1:0] dvsr_reg, dvsr_next;

    logic [DIVR_W:0]   shifted;
    logic [DIVR_W:0]   trial;
    logic              fits;

    assign shifted = {rem_reg, q_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, dvsr_reg};
    assign fits    = shifted >= {1'b0, dvsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = req.dividend;
            rem_next  = '0;
            dvsr_next = req.divisor;
        end else if (busy_reg) begin
            rem_next = fits ? trial[DIVR_W-1:0] : shifted[DIVR_W-1:0];
            q_next   = {q_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: hdl/ufbs_search.sv
// Search sequencer: walks multiplier/add pairs and keeps the best divisor.
// Depends on ufbs_pkg; drives one shared ufbs_div through its request struct.
module ufbs_search #(
    parameter int FRAC_MAX = ufbs_pkg::FRAC_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [ufbs_pkg::BAUD_W-1:0]       target_baud,
    input  logic [ufbs_pkg::CLK_W-1:0]        core_clock_hz,
    input  logic [ufbs_pkg::PCT_W-1:0]        err_percent,
    input  logic                              res_ready,
    output logic                              idle,
    output ufbs_pkg::srch_res_t               res,
    output ufbs_pkg::div_req_t                div_req,
    input  ufbs_pkg::div_rsp_t                div_rsp
);
    import ufbs_pkg::*;

    srch_state_t        state_reg, state_next;
    logic [BAUD_W-1:0]  baud_reg, baud_next;
    logic [BASE_W-1:0]  base_reg, base_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [FRAC_W-1:0]  m_reg, m_next;
    logic [FRAC_W-1:0]  a_reg, a_next;
    logic [DIV_W-1:0]   scaled_reg, scaled_next;
    logic [CAND_W-1:0]  divc_reg, divc_next;
    logic [ERR_W-1:0]   best_err_reg, best_err_next;
    logic [DVSR_W-1:0]  best_div_reg, best_div_next;
    logic [FRAC_W-1:0]  best_mul_reg, best_mul_next;
    logic [FRAC_W-1:0]  best_add_reg, best_add_next;

    logic [FRAC_W:0]    pair_sum;
    logic [DIV_W-1:0]   prod;
    logic               round_up;
    logic [CAND_W-1:0]  divc_calc;
    logic               cand_ok;
    logic [DIV_W-1:0]   baud_ext;
    logic [DIV_W-1:0]   err_calc;
    logic               err_better;
    logic               last_a, last_m;

    assign pair_sum   = (FRAC_W+1)'(m_reg) + (FRAC_W+1)'(a_reg);
    assign prod       = DIV_W'(base_reg) * DIV_W'(m_reg);
    assign round_up   = div_rsp.remainder > DIVR_W'(baud_reg[BAUD_W-1:1]);
    assign divc_calc  = CAND_W'(div_rsp.quotient) + CAND_W'(round_up);
    assign cand_ok    = (divc_reg >= CAND_W'(DIV_MIN)) && (divc_reg <= CAND_W'(DIV_MAX));
    assign baud_ext   = DIV_W'(baud_reg);
    assign err_calc   = (div_rsp.quotient <= baud_ext) ? (baud_ext - div_rsp.quotient)
                                                       : (div_rsp.quotient - baud_ext);
    assign err_better = err_calc < DIV_W'(best_err_reg);
    assign last_a     = a_reg == FRAC_W'(FRAC_MAX);
    assign last_m     = m_reg == FRAC_W'(FRAC_MAX);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (start) state_next = S_LIMIT;
            S_LIMIT:   if (div_rsp.done) begin
                state_next = (baud_reg == '0) ? S_FINISH : S_LAUNCH;
            end
            S_LAUNCH:  state_next = S_SCALE;
            S_SCALE:   if (div_rsp.done) state_next = S_DIVQ;
            S_DIVQ:    if (div_rsp.done) state_next = S_CHECK;
            S_CHECK:   state_next = cand_ok ? S_RATE : S_ADVANCE;
            S_RATE:    if (div_rsp.done) begin
                // stop the whole search at an exact match
                state_next = (err_better && err_calc == '0) ? S_FINISH : S_ADVANCE;
            end
            S_ADVANCE: state_next = (last_a && last_m) ? S_FINISH : S_LAUNCH;
            S_FINISH:  if (res_ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath and divider requests
    always_comb begin
        baud_next        = baud_reg;
        base_next        = base_reg;
        limit_next       = limit_reg;
        m_next           = m_reg;
        a_next           = a_reg;
        scaled_next      = scaled_reg;
        divc_next        = divc_reg;
        best_err_next    = best_err_reg;
        best_div_next    = best_div_reg;
        best_mul_next    = best_mul_reg;
        best_add_next    = best_add_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (state_reg)
            S_IDLE: if (start) begin
                baud_next        = target_baud;
                base_next        = core_clock_hz[CLK_W-1:6];
                best_err_next    = NO_ERROR_YET;
                best_div_next    = '0;
                best_mul_next    = FRAC_W'(1);
                best_add_next    = '0;
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'((BAUD_W+PCT_W)'(target_baud)
                                          * (BAUD_W+PCT_W)'(err_percent));
                div_req.divisor  = DIVR_W'(LIMIT_DEN);
            end
            S_LIMIT: if (div_rsp.done) begin
                limit_next = div_rsp.quotient[LIMIT_W-1:0];
                m_next     = FRAC_W'(1);
                a_next     = '0;
            end
            S_LAUNCH: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod;
                div_req.divisor  = DIVR_W'(pair_sum);
            end
            S_SCALE: if (div_rsp.done) begin
                scaled_next      = div_rsp.quotient;
                div_req.start    = 1'b1;
                div_req.dividend = div_rsp.quotient;
                div_req.divisor  = baud_reg;
            end
            S_DIVQ: if (div_rsp.done) begin
                divc_next = divc_calc;
            end
            S_CHECK: if (cand_ok) begin
                div_req.start    = 1'b1;
                div_req.dividend = scaled_reg;
                div_req.divisor  = DIVR_W'(divc_reg[DVSR_W-1:0]);
            end
            S_RATE: if (div_rsp.done && err_better) begin
                best_err_next = err_calc[ERR_W-1:0];
                best_div_next = divc_reg[DVSR_W-1:0];
                best_mul_next = m_reg;
                best_add_next = a_reg;
            end
            S_ADVANCE: begin
                if (last_a) begin
                    a_next = '0;
                    m_next = m_reg + FRAC_W'(1);
                end else begin
                    a_next = a_reg + FRAC_W'(1);
                end
            end
            S_FINISH: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        baud_reg     <= baud_next;
        base_reg     <= base_next;
        limit_reg    <= limit_next;
        m_reg        <= m_next;
        a_reg        <= a_next;
        scaled_reg   <= scaled_next;
        divc_reg     <= divc_next;
        best_err_reg <= best_err_next;
        best_div_reg <= best_div_next;
        best_mul_reg <= best_mul_next;
        best_add_reg <= best_add_next;
    end

    assign idle           = state_reg == S_IDLE;
    assign res.valid      = state_reg == S_FINISH;
    assign res.status     = !(LIMIT_W'(best_err_reg) < limit_reg);
    assign res.divisor    = best_div_reg;
    assign res.mul_value  = best_mul_reg;
    assign res.add_value  = best_add_reg;
    assign res.rate_error = best_err_reg;

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_LIMIT || state_reg == S_SCALE ||
                          state_reg == S_DIVQ || state_reg == S_RATE))
        else $error("divider result arrived with no state waiting for it");

    a_best_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (best_err_reg <= NO_ERROR_YET))
        else $error("best error above the no-candidate value");

    a_none_found: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> ((res.divisor == '0) == (res.rate_error == NO_ERROR_YET)))
        else $error("divisor and error disagree on whether a candidate was found");

endmodule

// File: tb/sv/uart_fractional_baud_search_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for uart_fractional_baud_search: streams target baud rates,
// predicts the best fractional divider setting per rate and checks every result.
// Depends on ufbs_pkg and the uart_fractional_baud_search RTL.
module uart_fractional_baud_search_tb;
    import ufbs_pkg::*;

    localparam int unsigned LIMIT_CYCLES  = 16_000_000;
    localparam int          SETTLE_CYCLES = 64;
    localparam int          MAX_WAIT      = 12;
    localparam int          RANDOM_PHASES = 5;
    localparam int          PHASE_ITEMS   = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(9);

    localparam int unsigned STD_BAUDS [16] = '{
        300, 1200, 2400, 4800, 9600, 14400, 19200, 38400,
        57600, 115200, 230400, 460800, 921600, 1000000, 1500000, 3000000
    };
    localparam int unsigned STD_CLOCKS [7] = '{
        100000000, 120000000, 96000000, 72000000, 25000000, 18432000, 12000000
    };

    typedef struct packed {
        logic              status;
        logic [DVSR_W-1:0] divisor;
        logic [FRAC_W-1:0] mul_value;
        logic [FRAC_W-1:0] add_value;
        logic [ERR_W-1:0]  rate_error;
    } baud_setting_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Register copies seen by the predictor
    logic [CLK_W-1:0] core_clk_hz = CORE_CLOCK_RST;
    logic [PCT_W-1:0] err_pct = ERR_PCT_RST;

    logic [BAUD_W-1:0] pending_bauds[$];
    baud_setting_t     expected_settings[$];

    bit          no_idle = 1'b0;
    int          send_gap = 0;
    int          recv_hold = 0;
    int          recv_wait;
    int unsigned cycle_count = 0;
    int          mismatches = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          settings_used = 1;
    int          none_valid = 0;
    int          exact_hits = 0;
    baud_setting_t want;
    baud_setting_t predicted;

    uart_fractional_baud_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Walk the multiplier/add pairs until an exact match and keep the first strictly smaller error.
    function automatic baud_setting_t best_setting(input logic [BAUD_W-1:0] baud);
        longint unsigned b, clk, base, scaled, dvsr, rate, err, best_err, limit;
        baud_setting_t   r;
        bit              exact;
        int              m, a;
        b        = baud;
        clk      = core_clk_hz;
        base     = (clk / 4) / 16;
        best_err = NO_ERROR_YET;
        exact    = 1'b0;
        r.divisor   = '0;
        r.mul_value = FRAC_W'(1);
        r.add_value = '0;
        if (b != 0) begin
            for (m = 1; m <= FRAC_MAX_DEF && !exact; m++) begin
                for (a = 0; a <= FRAC_MAX_DEF; a++) begin
                    scaled = (m * base) / (m + a);
                    dvsr = scaled / b;
                    if ((scaled % b) > (b / 2))
                        dvsr++;
                    if (dvsr < DIV_MIN || dvsr > DIV_MAX)
                        continue;
                    rate = scaled / dvsr;
                    err = (rate <= b) ? (b - rate) : (rate - b);
                    if (err < best_err) begin
                        best_err    = err;
                        r.divisor   = DVSR_W'(dvsr);
                        r.mul_value = FRAC_W'(m);
                        r.add_value = FRAC_W'(a);
                        if (err == 0) begin
                            exact = 1'b1;
                            break;
                        end
                    end
                end
            end
        end
        limit = (b * err_pct) / LIMIT_DEN;
        r.status     = (best_err < limit) ? 1'b0 : 1'b1;
        r.rate_error = ERR_W'(best_err);
        return r;
    endfunction

    function automatic int draw_wait();
        if (no_idle)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [BAUD_W-1:0] draw_baud();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return BAUD_W'(STD_BAUDS[$urandom_range(0, 15)]);
        else if (pick < 70)
            return BAUD_W'($urandom_range(1, 4000000));
        else if (pick < 85)
            return BAUD_W'($urandom);
        else if (pick < 95)
            return BAUD_W'($urandom_range(1, 2000));
        return '0;
    endfunction

    function automatic logic [31:0] draw_clock();
        int unsigned pick;
        pick = $urandom_range(0, 3);
        if (pick < 2)
            return STD_CLOCKS[$urandom_range(0, 6)];
        else if (pick == 2)
            return $urandom;
        return $urandom_range(64, 200000000);
    endfunction

    task automatic check_field(input string field, input longint unsigned exp_val,
                               input longint unsigned act_val);
        if (exp_val != act_val) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, field, exp_val, act_val);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued rate has been sent and every result returned.
    // Sample at the falling edge so the driver and monitor updates have settled.
    task automatic drain();
        do @(negedge aclk);
        while (pending_bauds.size() != 0 || s_tvalid || expected_settings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Track register writes for the predictor
    always @(posedge aclk) begin
        if (!aresetn) begin
            core_clk_hz <= CORE_CLOCK_RST;
            err_pct     <= ERR_PCT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IDX_CORE_CLOCK: core_clk_hz <= cfg_data;
                CFG_IDX_ERR_PCT:    err_pct <= cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid) begin
                predicted = best_setting(s_tdata[BAUD_W-1:0]);
                expected_settings.push_back(predicted);
                items_sent++;
                if (predicted.divisor == '0)
                    none_valid++;
                if (predicted.divisor != '0 && predicted.rate_error == '0)
                    exact_hits++;
            end
            if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_bauds.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, pending_bauds.pop_front()};
                send_gap <= draw_wait();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: stall only while a result is offered
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_hold <= 0;
        end else if (m_tvalid && m_tready) begin
            if (expected_settings.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected result, tdata %h tuser %b",
                         $time, m_tdata, m_tuser);
            end else begin
                want = expected_settings.pop_front();
                check_field("status",     want.status,     m_tuser);
                check_field("divisor",    want.divisor,    m_tdata[15:0]);
                check_field("mul_value",  want.mul_value,  m_tdata[19:16]);
                check_field("add_value",  want.add_value,  m_tdata[23:20]);
                check_field("rate_error", want.rate_error, m_tdata[40:24]);
                results_checked++;
            end
            recv_wait = draw_wait();
            recv_hold <= recv_wait;
            m_tready  <= (recv_wait == 0);
        end else if (m_tvalid && recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            m_tready  <= (recv_hold == 1);
        end else if (recv_hold == 0) begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results still due",
                     cycle_count, expected_settings.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int ph, i;
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: zero rate, unreachable rates, exact hits, bit patterns
        pending_bauds = '{22'd0, 22'd1, 22'd2, 22'd9600, 22'd115200, 22'd15625,
                          22'd520833, 22'd4000000, 22'h3FFFFF, 22'h2AAAAA,
                          22'h155555, 22'd1562500};
        drain();

        // Zero core clock: nothing can be valid
        write_reg(CFG_IDX_CORE_CLOCK, 32'd0);
        write_reg(CFG_IDX_ERR_PCT, 32'd100);
        settings_used++;
        pending_bauds = '{22'd9600, 22'd1};
        drain();

        // Fastest clock, zero tolerance
        write_reg(CFG_IDX_CORE_CLOCK, 32'hFFFF_FFFF);
        write_reg(CFG_IDX_ERR_PCT, 32'd0);
        settings_used++;
        no_idle = 1'b1;
        pending_bauds = '{22'd115200, 22'd4000000, 22'd3};
        drain();

        // Slowest clock, percent above 100, and a write to an unused index
        write_reg(CFG_IDX_CORE_CLOCK, 32'd1);
        write_reg(CFG_IDX_ERR_PCT, 32'd127);
        write_reg(CFG_IDX_SPARE, 32'd5);
        settings_used++;
        no_idle = 1'b0;
        pending_bauds = '{22'd1, 22'd9600};
        drain();

        write_reg(CFG_IDX_CORE_CLOCK, 32'd120000000);
        write_reg(CFG_IDX_ERR_PCT, 32'd5);
        settings_used++;
        pending_bauds = '{22'd0, 22'd57600, 22'd921600};
        drain();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if ($urandom_range(0, 1))
                write_reg(CFG_IDX_CORE_CLOCK, draw_clock());
            write_reg(CFG_IDX_ERR_PCT, ($urandom & ~32'h7F) |
                      (($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                    : $urandom_range(0, 100)));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_SPARE, $urandom);
            write_reg(CFG_IDX_CORE_CLOCK, draw_clock());
            settings_used++;
            no_idle = ($urandom_range(0, 3) == 0);
            for (i = 0; i < PHASE_ITEMS; i++)
                pending_bauds.push_back(draw_baud());
            drain();
        end

        $display("Sent %0d baud requests over %0d register settings, checked %0d results",
                 items_sent, settings_used, results_checked);
        $display("%0d requests had no usable divisor, %0d hit an exact rate",
                 none_valid, exact_hits);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
